/* src/source_character_lexer_unit_assert.svh */
// Assertion macros for the lexer.
`ifndef SOURCE_CHARACTER_LEXER_UNIT_ASSERT_SVH
`define SOURCE_CHARACTER_LEXER_UNIT_ASSERT_SVH

// Consequent checked in the same cycle.
`define SCLU_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the next cycle.
`define SCLU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/scl_pkg.sv */
package scl_pkg;

  localparam int DEF_MAX_TOKEN_LEN = 256;
  localparam int DEF_HOLD_DEPTH    = 32;
  localparam int DEF_NEST_WIDTH    = 16;
  localparam int QUEUE_DEPTH       = 4;

  localparam logic [2:0] CLS_NEWLINE = 3'd0;
  localparam logic [2:0] CLS_SPECIAL = 3'd1;
  localparam logic [2:0] CLS_COMPARE = 3'd2;
  localparam logic [2:0] CLS_ARITH   = 3'd3;
  localparam logic [2:0] CLS_STRING  = 3'd4;
  localparam logic [2:0] CLS_IDENT   = 3'd5;
  localparam logic [2:0] CLS_GLOBAL  = 3'd6;
  localparam logic [2:0] CLS_NUMBER  = 3'd7;

  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_INVALID     = 3'd1;
  localparam logic [2:0] ERR_UNSUPPORTED = 3'd2;
  localparam logic [2:0] ERR_UNCLOSED    = 3'd3;
  localparam logic [2:0] ERR_OVERFLOW    = 3'd4;

  typedef struct packed {
    logic [7:0] source_char;
    logic       end_of_input;
  } in_word_t;

  typedef struct packed {
    logic [2:0] token_class;
    logic [7:0] text_char;
    logic       has_char;
    logic       token_last;
    logic [2:0] error_code;
  } out_word_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
    logic       digit;
    logic       alpha;
    logic       space;
    logic       blank;
    logic       xdigit;
    logic       special;
    logic       boundary;
    logic       esc_ok;
    logic [7:0] esc_val;
    logic [3:0] hex;
  } char_info_t;

endpackage

/* src/source_character_lexer_unit.sv */
// Words reach dout through the registered input and output queues. Characters leave one
// byte late, so a token's last word waits for the byte after it. Throughput: one byte per
// cycle while the output queue has room; a byte that closes one token and opens another,
// or follows a newline and a lone slash, is lexed again from the start state; a compare
// pair sends '=' from a tail state; a triple-quoted flush first replays the held bytes.
// Reset (rst, synchronous): queues empty, lexer at start state, halt cleared.
module source_character_lexer_unit #(
  parameter int MAX_TOKEN_LEN = scl_pkg::DEF_MAX_TOKEN_LEN,
  parameter int HOLD_DEPTH    = scl_pkg::DEF_HOLD_DEPTH,
  parameter int NEST_WIDTH    = scl_pkg::DEF_NEST_WIDTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  scl_pkg::in_word_t  din,
  output logic               empty,
  input  logic               pop,
  output scl_pkg::out_word_t dout
);

  import scl_pkg::*;

  char_info_t info;
  char_info_t q_item;
  logic       q_empty;
  logic       q_pop;
  out_word_t  res_word;
  logic       res_push;
  logic       res_full;

  scl_front u_front (
    .din  (din),
    .info (info)
  );

  scl_fifo #(
    .word_t (char_info_t),
    .DEPTH  (QUEUE_DEPTH)
  ) u_in_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (info),
    .full  (full),
    .pop   (q_pop),
    .rdata (q_item),
    .empty (q_empty)
  );

  scl_back #(
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
    .HOLD_DEPTH    (HOLD_DEPTH),
    .NEST_WIDTH    (NEST_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (q_item),
    .item_valid (!q_empty),
    .item_pop   (q_pop),
    .oword      (res_word),
    .opush      (res_push),
    .ofull      (res_full)
  );

  scl_fifo #(
    .word_t (out_word_t),
    .DEPTH  (QUEUE_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_word),
    .full  (res_full),
    .pop   (pop),
    .rdata (dout),
    .empty (empty)
  );

endmodule

/* src/scl_fifo.sv */
module scl_fifo #(
  parameter type word_t = logic,
  parameter int  DEPTH  = 4
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  word_t wdata,
  output logic  full,
  input  logic  pop,
  output word_t rdata,
  output logic  empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LAST = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FULL_CNT = CntW'(DEPTH);

  word_t           mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

/* src/scl_front.sv */
module scl_front (
  input  scl_pkg::in_word_t   din,
  output scl_pkg::char_info_t info
);

  import scl_pkg::*;

  logic [7:0] c;
  logic [7:0] lc;
  logic       is_dig;

  assign c      = din.source_char;
  assign lc     = c | 8'h20;
  assign is_dig = (c >= "0") && (c <= "9");

  always_comb begin
    info          = '0;
    info.ch       = c;
    info.eoi      = din.end_of_input;
    info.digit    = is_dig;
    info.alpha    = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    info.space    = (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
    info.blank    = (c == " ") || (c == 8'd9);
    info.xdigit   = is_dig || ((lc >= "a") && (lc <= "f"));
    info.hex      = is_dig ? c[3:0] : lc[3:0] + 4'd9;
    info.special  = c inside {"(", ")", "{", "}", ",", ".", "?", ":"};
    info.boundary = c inside {"(", ")", "{", "}", ",", ".", "<", "=", ">",
                              "/", "+", "-", "*", "!"};
    unique case (c)
      "n":     begin info.esc_ok = 1'b1; info.esc_val = 8'd10; end
      "t":     begin info.esc_ok = 1'b1; info.esc_val = 8'd9;  end
      "r":     begin info.esc_ok = 1'b1; info.esc_val = 8'd13; end
      "\"":    begin info.esc_ok = 1'b1; info.esc_val = 8'd34; end
      "\\":    begin info.esc_ok = 1'b1; info.esc_val = 8'd92; end
      default: begin info.esc_ok = 1'b0; info.esc_val = 8'd0;  end
    endcase
  end

endmodule

/* src/scl_back.sv */
module scl_back #(
  parameter int MAX_TOKEN_LEN = 256,
  parameter int HOLD_DEPTH    = 32,
  parameter int NEST_WIDTH    = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  scl_pkg::char_info_t  item,
  input  logic                 item_valid,
  output logic                 item_pop,
  output scl_pkg::out_word_t   oword,
  output logic                 opush,
  input  logic                 ofull
);

  import scl_pkg::*;

  localparam int TlW = $clog2(MAX_TOKEN_LEN);
  localparam int HcW = $clog2(HOLD_DEPTH + 1);
  localparam int HaW = $clog2(HOLD_DEPTH);
  localparam logic [TlW-1:0]        TL_LIMIT  = TlW'(MAX_TOKEN_LEN - 1);
  localparam logic [HcW-1:0]        HOLD_FULL = HcW'(HOLD_DEPTH);
  localparam logic [NEST_WIDTH-1:0] DEPTH_MAX = '1;

  typedef enum logic [5:0] {
    M_START, M_NL, M_NL_SLASH, M_SLASH, M_LINE,
    M_BC_SEEK, M_BC_STAR, M_BC_SLASH, M_BCN_SEEK, M_BCN_STAR, M_BCN_SLASH,
    M_EQ, M_GL, M_NEQ,
    M_STR, M_STR_EMPTY, M_STR_ESC, M_STR_HEX1, M_STR_HEX2,
    M_MULTI, M_MULTI_Q, M_MULTI_END,
    M_IDENT,
    M_N_ZERO, M_N_DEC, M_N_FRAC_START, M_N_FRAC, M_N_EXP_SIGN, M_N_EXP_START,
    M_N_EXP, M_N_HEX_START, M_N_HEX,
    M_TAIL
  } mode_t;

  typedef enum logic [1:0] {F_IDLE, F_PRIME, F_RUN} flush_t;

  function automatic out_word_t mk_word(logic [2:0] cls, logic [7:0] ch, logic has,
                                        logic last, logic [2:0] err);
    out_word_t w;
    w.token_class = cls;
    w.text_char   = ch;
    w.has_char    = has;
    w.token_last  = last;
    w.error_code  = err;
    return w;
  endfunction

  mode_t                 mode, mode_next;
  logic [NEST_WIDTH-1:0] depth, depth_next;
  logic [TlW-1:0]        tl, tl_next;
  logic [7:0]            pend_ch, pend_ch_next;
  logic                  pv, pv_next;
  logic [3:0]            hex_high, hex_high_next;
  logic [2:0]            flags, flags_next;
  logic [HcW-1:0]        hcount, hcount_next;
  logic                  halted, halted_next;
  flush_t                fstate, fstate_next;
  logic [HcW-1:0]        fidx, fidx_next;

  logic [7:0]            held [HOLD_DEPTH];
  logic [7:0]            rdata;
  logic [HaW-1:0]        rd_addr;
  logic                  hwe;

  logic [7:0]            c;
  logic                  go;
  logic                  item_step;
  logic                  clr;
  logic                  set_us;
  logic                  pc_req;
  logic [2:0]            pc_cls;
  logic [7:0]            pc_ch;
  logic                  push_req;
  logic                  fail_req;
  logic [2:0]            fail_code;
  logic [2:0]            nf;
  logic [2:0]            icls;
  logic                  bcn;
  mode_t                 seek_m;
  logic [7:0]            hv;

  assign c    = item.ch;
  assign go   = !ofull;
  assign bcn  = (mode == M_BCN_SEEK) || (mode == M_BCN_STAR) || (mode == M_BCN_SLASH);
  assign seek_m = bcn ? M_BCN_SEEK : M_BC_SEEK;
  assign icls = (flags[1:0] == 2'b11) ? CLS_GLOBAL : CLS_IDENT;
  assign hv   = {hex_high, item.hex};

  always_comb begin
    mode_next     = mode;
    depth_next    = depth;
    tl_next       = tl;
    pend_ch_next  = pend_ch;
    pv_next       = pv;
    hex_high_next = hex_high;
    flags_next    = flags;
    hcount_next   = hcount;
    halted_next   = halted;
    fstate_next   = fstate;
    fidx_next     = fidx;
    opush         = 1'b0;
    oword         = '0;
    item_pop      = 1'b0;
    item_step     = 1'b0;
    clr           = 1'b0;
    set_us        = 1'b0;
    pc_req        = 1'b0;
    pc_cls        = CLS_STRING;
    pc_ch         = c;
    push_req      = 1'b0;
    fail_req      = 1'b0;
    fail_code     = ERR_NONE;
    hwe           = 1'b0;
    nf            = flags;
    rd_addr       = (fstate == F_RUN) ? HaW'(go ? fidx + 1'b1 : fidx) : '0;

    if (halted) begin
      item_pop = item_valid;
    end else if (fstate == F_PRIME) begin
      fstate_next = F_RUN;
    end else if (fstate == F_RUN) begin
      if (go) begin
        pc_req    = 1'b1;
        pc_cls    = CLS_STRING;
        pc_ch     = rdata;
        fidx_next = fidx + 1'b1;
        if (HcW'(fidx + 1'b1) == hcount) begin
          fstate_next = F_IDLE;
          fidx_next   = '0;
          hcount_next = '0;
        end
      end
    end else if (mode == M_TAIL) begin
      if (go) begin
        opush     = 1'b1;
        oword     = mk_word(CLS_COMPARE, "=", 1'b1, 1'b1, ERR_NONE);
        mode_next = M_START;
      end
    end else if (item_valid && go) begin
      item_step = 1'b1;
      item_pop  = 1'b1;
      if (item.eoi) begin
        clr       = 1'b1;
        mode_next = M_START;
        unique case (mode)
          M_NL, M_LINE: begin
            opush = 1'b1;
            oword = mk_word(CLS_NEWLINE, 8'd0, 1'b0, 1'b1, ERR_NONE);
          end
          M_NL_SLASH: begin
            opush     = 1'b1;
            oword     = mk_word(CLS_NEWLINE, 8'd0, 1'b0, 1'b1, ERR_NONE);
            clr       = 1'b0;
            mode_next = M_SLASH;
            item_pop  = 1'b0;
          end
          M_SLASH: begin
            opush = 1'b1;
            oword = mk_word(CLS_ARITH, "/", 1'b1, 1'b1, ERR_NONE);
          end
          M_BC_SEEK, M_BC_STAR, M_BC_SLASH, M_BCN_SEEK, M_BCN_STAR, M_BCN_SLASH: begin
            fail_req  = 1'b1;
            fail_code = ERR_UNCLOSED;
          end
          M_EQ: begin
            opush = 1'b1;
            oword = mk_word(CLS_SPECIAL, "=", 1'b1, 1'b1, ERR_NONE);
          end
          M_GL: begin
            opush = 1'b1;
            oword = mk_word(CLS_COMPARE, pend_ch, 1'b1, 1'b1, ERR_NONE);
          end
          M_STR_EMPTY: begin
            opush = 1'b1;
            oword = mk_word(CLS_STRING, pv ? pend_ch : 8'd0, pv, 1'b1, ERR_NONE);
          end
          M_IDENT: begin
            if (((tl == TlW'(1)) && flags[0]) || flags[2]) begin
              fail_req  = 1'b1;
              fail_code = ERR_INVALID;
            end else begin
              opush = 1'b1;
              oword = mk_word(icls, pv ? pend_ch : 8'd0, pv, 1'b1, ERR_NONE);
            end
          end
          M_N_ZERO, M_N_DEC, M_N_FRAC, M_N_EXP, M_N_HEX: begin
            opush = 1'b1;
            oword = mk_word(CLS_NUMBER, pv ? pend_ch : 8'd0, pv, 1'b1, ERR_NONE);
          end
          M_START: begin
          end
          default: begin
            fail_req  = 1'b1;
            fail_code = ERR_INVALID;
          end
        endcase
      end else begin
        unique case (mode)
          M_START: begin
            clr = 1'b1;
            if (c == 8'd10) begin
              mode_next = M_NL;
            end else if (item.blank) begin
            end else if (item.special) begin
              opush = 1'b1;
              oword = mk_word(CLS_SPECIAL, c, 1'b1, 1'b1, ERR_NONE);
            end else if (c == "=") begin
              pend_ch_next = c;
              mode_next    = M_EQ;
            end else if (c == "!") begin
              pend_ch_next = c;
              mode_next    = M_NEQ;
            end else if ((c == "<") || (c == ">")) begin
              pend_ch_next = c;
              mode_next    = M_GL;
            end else if ((c == "+") || (c == "-") || (c == "*")) begin
              opush = 1'b1;
              oword = mk_word(CLS_ARITH, c, 1'b1, 1'b1, ERR_NONE);
            end else if (c == "/") begin
              mode_next = M_SLASH;
            end else if (c == "\"") begin
              mode_next = M_STR;
            end else if (item.alpha || (c == "_")) begin
              set_us    = (c == "_");
              pc_req    = 1'b1;
              pc_cls    = CLS_IDENT;
              mode_next = M_IDENT;
            end else if (item.digit) begin
              pc_req    = 1'b1;
              pc_cls    = CLS_NUMBER;
              mode_next = (c == "0") ? M_N_ZERO : M_N_DEC;
            end else begin
              fail_req  = 1'b1;
              fail_code = ERR_UNSUPPORTED;
            end
          end
          M_NL: begin
            if (item.space) begin
            end else if (c == "/") begin
              mode_next = M_NL_SLASH;
            end else begin
              opush     = 1'b1;
              oword     = mk_word(CLS_NEWLINE, 8'd0, 1'b0, 1'b1, ERR_NONE);
              mode_next = M_START;
              item_pop  = 1'b0;
            end
          end
          M_NL_SLASH: begin
            if (c == "*") begin
              depth_next = NEST_WIDTH'(1);
              mode_next  = M_BCN_SEEK;
            end else if (c == "/") begin
              mode_next = M_LINE;
            end else begin
              opush     = 1'b1;
              oword     = mk_word(CLS_NEWLINE, 8'd0, 1'b0, 1'b1, ERR_NONE);
              mode_next = M_SLASH;
              item_pop  = 1'b0;
            end
          end
          M_SLASH: begin
            if (c == "*") begin
              depth_next = NEST_WIDTH'(1);
              mode_next  = M_BC_SEEK;
            end else if (c == "/") begin
              mode_next = M_LINE;
            end else begin
              opush     = 1'b1;
              oword     = mk_word(CLS_ARITH, "/", 1'b1, 1'b1, ERR_NONE);
              mode_next = M_START;
              item_pop  = 1'b0;
            end
          end
          M_LINE: begin
            if (c == 8'd10) begin
              mode_next = M_NL;
            end
          end
          M_BC_SEEK, M_BCN_SEEK: begin
            if (c == "*") begin
              mode_next = bcn ? M_BCN_STAR : M_BC_STAR;
            end else if (c == "/") begin
              mode_next = bcn ? M_BCN_SLASH : M_BC_SLASH;
            end
          end
          M_BC_STAR, M_BCN_STAR: begin
            if (c == "/") begin
              depth_next = depth - 1'b1;
              if (depth == NEST_WIDTH'(1)) begin
                mode_next = bcn ? M_NL : M_START;
              end else begin
                mode_next = seek_m;
              end
            end else if (c != "*") begin
              mode_next = seek_m;
            end
          end
          M_BC_SLASH, M_BCN_SLASH: begin
            mode_next = seek_m;
            if (c == "*") begin
              if (depth >= DEPTH_MAX) begin
                fail_req  = 1'b1;
                fail_code = ERR_OVERFLOW;
              end else begin
                depth_next = depth + 1'b1;
              end
            end
          end
          M_EQ: begin
            opush = 1'b1;
            if (c == "=") begin
              oword     = mk_word(CLS_COMPARE, "=", 1'b1, 1'b0, ERR_NONE);
              mode_next = M_TAIL;
            end else begin
              oword     = mk_word(CLS_SPECIAL, "=", 1'b1, 1'b1, ERR_NONE);
              mode_next = M_START;
              item_pop  = 1'b0;
            end
          end
          M_GL: begin
            opush = 1'b1;
            if (c == "=") begin
              oword     = mk_word(CLS_COMPARE, pend_ch, 1'b1, 1'b0, ERR_NONE);
              mode_next = M_TAIL;
            end else begin
              oword     = mk_word(CLS_COMPARE, pend_ch, 1'b1, 1'b1, ERR_NONE);
              mode_next = M_START;
              item_pop  = 1'b0;
            end
          end
          M_NEQ: begin
            if (c == "=") begin
              opush     = 1'b1;
              oword     = mk_word(CLS_COMPARE, "!", 1'b1, 1'b0, ERR_NONE);
              mode_next = M_TAIL;
            end else begin
              fail_req  = 1'b1;
              fail_code = ERR_INVALID;
            end
          end
          M_STR: begin
            if (c == "\"") begin
              if (tl == '0) begin
                mode_next = M_STR_EMPTY;
              end else begin
                opush     = 1'b1;
                oword     = mk_word(CLS_STRING, pend_ch, pv, 1'b1, ERR_NONE);
                clr       = 1'b1;
                mode_next = M_START;
              end
            end else if (c == "\\") begin
              mode_next = M_STR_ESC;
            end else if ((c < 8'd32) || (c == 8'd127)) begin
              fail_req  = 1'b1;
              fail_code = ERR_INVALID;
            end else begin
              pc_req = 1'b1;
            end
          end
          M_STR_EMPTY: begin
            if (c == "\"") begin
              hcount_next = '0;
              mode_next   = M_MULTI;
            end else begin
              opush     = 1'b1;
              oword     = mk_word(CLS_STRING, pv ? pend_ch : 8'd0, pv, 1'b1, ERR_NONE);
              clr       = 1'b1;
              mode_next = M_START;
              item_pop  = 1'b0;
            end
          end
          M_STR_ESC: begin
            if (c == "x") begin
              mode_next = M_STR_HEX1;
            end else if (item.esc_ok) begin
              pc_req    = 1'b1;
              pc_ch     = item.esc_val;
              mode_next = M_STR;
            end else begin
              fail_req  = 1'b1;
              fail_code = ERR_INVALID;
            end
          end
          M_STR_HEX1: begin
            if (item.xdigit) begin
              hex_high_next = item.hex;
              mode_next     = M_STR_HEX2;
            end else begin
              fail_req  = 1'b1;
              fail_code = ERR_INVALID;
            end
          end
          M_STR_HEX2: begin
            if (!item.xdigit || hv[7]) begin
              fail_req  = 1'b1;
              fail_code = ERR_INVALID;
            end else begin
              pc_req    = 1'b1;
              pc_ch     = hv;
              mode_next = M_STR;
            end
          end
          M_MULTI: begin
            if (item.space) begin
              push_req = 1'b1;
            end else if (c == "\"") begin
              push_req  = 1'b1;
              mode_next = M_MULTI_Q;
            end else if (hcount != '0) begin
              fstate_next = F_PRIME;
              fidx_next   = '0;
              item_pop    = 1'b0;
            end else begin
              pc_req = 1'b1;
            end
          end
          M_MULTI_Q, M_MULTI_END: begin
            if (c == "\"") begin
              if (mode == M_MULTI_END) begin
                opush     = 1'b1;
                oword     = mk_word(CLS_STRING, pv ? pend_ch : 8'd0, pv, 1'b1, ERR_NONE);
                clr       = 1'b1;
                mode_next = M_START;
              end else begin
                push_req  = 1'b1;
                mode_next = M_MULTI_END;
              end
            end else if (hcount != '0) begin
              fstate_next = F_PRIME;
              fidx_next   = '0;
              item_pop    = 1'b0;
            end else begin
              pc_req    = 1'b1;
              mode_next = M_MULTI;
            end
          end
          M_IDENT: begin
            if (item.alpha || item.digit || (c == "_")) begin
              if ((tl == TlW'(1)) && (c == "_") && flags[0]) begin
                nf[1] = 1'b1;
              end else if ((tl == TlW'(2)) && (flags[1:0] == 2'b11) && !item.alpha) begin
                nf[2] = 1'b1;
              end
              flags_next = nf;
              pc_req     = 1'b1;
              pc_cls     = (nf[1:0] == 2'b11) ? CLS_GLOBAL : CLS_IDENT;
            end else if (!item.space && !item.boundary) begin
              fail_req  = 1'b1;
              fail_code = ERR_INVALID;
            end else if (((tl == TlW'(1)) && flags[0]) || flags[2]) begin
              fail_req  = 1'b1;
              fail_code = ERR_INVALID;
            end else begin
              opush     = 1'b1;
              oword     = mk_word(icls, pv ? pend_ch : 8'd0, pv, 1'b1, ERR_NONE);
              clr       = 1'b1;
              mode_next = M_START;
              item_pop  = 1'b0;
            end
          end
          M_N_ZERO, M_N_DEC, M_N_FRAC, M_N_EXP, M_N_HEX: begin
            pc_cls = CLS_NUMBER;
            if ((mode == M_N_ZERO) && ((c == "x") || (c == "X"))) begin
              pc_req    = 1'b1;
              pc_ch     = "x";
              mode_next = M_N_HEX_START;
            end else if ((mode == M_N_ZERO) && (c == "0")) begin
              fail_req  = 1'b1;
              fail_code = ERR_INVALID;
            end else if ((mode == M_N_HEX) && item.xdigit) begin
              pc_req = 1'b1;
            end else if ((mode == M_N_DEC || mode == M_N_FRAC || mode == M_N_EXP)
                         && item.digit) begin
              pc_req = 1'b1;
            end else if ((mode == M_N_ZERO || mode == M_N_DEC) && (c == ".")) begin
              pc_req    = 1'b1;
              mode_next = M_N_FRAC_START;
            end else if ((mode == M_N_ZERO || mode == M_N_DEC || mode == M_N_FRAC)
                         && ((c == "e") || (c == "E"))) begin
              pc_req    = 1'b1;
              pc_ch     = "e";
              mode_next = M_N_EXP_SIGN;
            end else begin
              opush     = 1'b1;
              oword     = mk_word(CLS_NUMBER, pv ? pend_ch : 8'd0, pv, 1'b1, ERR_NONE);
              clr       = 1'b1;
              mode_next = M_START;
              item_pop  = 1'b0;
            end
          end
          M_N_FRAC_START, M_N_EXP_START, M_N_EXP_SIGN, M_N_HEX_START: begin
            pc_cls = CLS_NUMBER;
            if ((mode == M_N_EXP_SIGN) && ((c == "+") || (c == "-"))) begin
              pc_req    = 1'b1;
              mode_next = M_N_EXP_START;
            end else if ((mode == M_N_HEX_START) && item.xdigit) begin
              pc_req    = 1'b1;
              mode_next = M_N_HEX;
            end else if ((mode != M_N_HEX_START) && item.digit) begin
              pc_req    = 1'b1;
              mode_next = (mode == M_N_FRAC_START) ? M_N_FRAC : M_N_EXP;
            end else begin
              fail_req  = 1'b1;
              fail_code = ERR_INVALID;
            end
          end
          default: begin
            mode_next = M_START;
            item_pop  = 1'b0;
          end
        endcase
      end
    end

    if (clr) begin
      pv_next       = 1'b0;
      tl_next       = '0;
      flags_next    = '0;
      hcount_next   = '0;
      hex_high_next = '0;
      depth_next    = '0;
    end
    if (set_us) begin
      flags_next = 3'b001;
    end

    if (pc_req) begin
      if (tl_next >= TL_LIMIT) begin
        fail_req  = 1'b1;
        fail_code = ERR_OVERFLOW;
      end else begin
        if (pv_next) begin
          opush = 1'b1;
          oword = mk_word(pc_cls, pend_ch_next, 1'b1, 1'b0, ERR_NONE);
        end
        pend_ch_next = pc_ch;
        pv_next      = 1'b1;
        tl_next      = tl_next + 1'b1;
      end
    end

    if (push_req) begin
      if (hcount_next >= HOLD_FULL) begin
        fail_req  = 1'b1;
        fail_code = ERR_OVERFLOW;
      end else begin
        hwe         = 1'b1;
        hcount_next = hcount_next + 1'b1;
      end
    end

    if (fail_req) begin
      opush         = 1'b1;
      oword         = mk_word(CLS_NEWLINE, 8'd0, 1'b0, 1'b1, fail_code);
      hwe           = 1'b0;
      pv_next       = 1'b0;
      tl_next       = '0;
      flags_next    = '0;
      hcount_next   = '0;
      hex_high_next = '0;
      depth_next    = '0;
      mode_next     = M_START;
      fstate_next   = F_IDLE;
      fidx_next     = '0;
      halted_next   = 1'b1;
      item_pop      = item_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= M_START;
      depth    <= '0;
      tl       <= '0;
      pv       <= 1'b0;
      hex_high <= '0;
      flags    <= '0;
      hcount   <= '0;
      halted   <= 1'b0;
      fstate   <= F_IDLE;
      fidx     <= '0;
    end else begin
      mode     <= mode_next;
      depth    <= depth_next;
      tl       <= tl_next;
      pv       <= pv_next;
      hex_high <= hex_high_next;
      flags    <= flags_next;
      hcount   <= hcount_next;
      halted   <= halted_next;
      fstate   <= fstate_next;
      fidx     <= fidx_next;
    end
    pend_ch <= pend_ch_next;
  end

  always_ff @(posedge clk) begin
    if (hwe) begin
      held[hcount[HaW-1:0]] <= c;
    end
    rdata <= held[rd_addr];
  end

  `include "source_character_lexer_unit_assert.svh"

  `SCLU_ASSERT_NEXT(a_halt_sticky, clk, rst, halted, halted, "halt flag dropped")
  `SCLU_ASSERT_NOW(a_quiet_halted, clk, rst, halted, !opush, "word sent while halted")
  `SCLU_ASSERT_NOW(a_flush_nonempty, clk, rst, fstate == F_RUN, hcount != '0,
                   "flush with no held bytes")
  `SCLU_ASSERT_NEXT(a_error_halts, clk, rst, opush && (oword.error_code != ERR_NONE),
                    halted, "error word without halt")

endmodule

/* verif/source_character_lexer_unit_tb.sv */
`timescale 1ns / 1ps

module source_character_lexer_unit_tb;
  import scl_pkg::*;

  localparam int TOKEN_MAX  = DEF_MAX_TOKEN_LEN;
  localparam int HOLD_MAX   = DEF_HOLD_DEPTH;
  localparam longint DEPTH_MAX = (longint'(1) << DEF_NEST_WIDTH) - 1;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 40;

  typedef enum int {
    LX_START, LX_NL, LX_NL_SLASH, LX_SLASH, LX_LINE,
    LX_BC_SEEK, LX_BC_STAR, LX_BC_SLASH, LX_BCN_SEEK, LX_BCN_STAR, LX_BCN_SLASH,
    LX_EQ, LX_GL, LX_NEQ,
    LX_STR, LX_STR_EMPTY, LX_STR_ESC, LX_STR_HEX1, LX_STR_HEX2,
    LX_MULTI, LX_MULTI_Q, LX_MULTI_END,
    LX_IDENT,
    LX_N_ZERO, LX_N_DEC, LX_N_FRAC_START, LX_N_FRAC, LX_N_EXP_SIGN, LX_N_EXP_START,
    LX_N_EXP, LX_N_HEX_START, LX_N_HEX
  } lex_mode_e;

  logic      clk;
  logic      rst;
  logic      push;
  logic      full;
  in_word_t  din;
  logic      empty;
  logic      pop;
  out_word_t dout;

  source_character_lexer_unit dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .din(din),
    .empty(empty), .pop(pop), .dout(dout)
  );

  out_word_t token_q[$];
  int        err_cnt;
  int        words_sent;
  bit        calm;
  int        pop_hold;

  // lexer shadow state
  int        lmode;
  longint    nest;
  int        tlen;
  bit [7:0]  pend_ch;
  bit        pend_v;
  bit [3:0]  hex_hi;
  bit [2:0]  pfx;
  bit [7:0]  held[HOLD_MAX];
  int        held_n;
  bit        halted;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic bit is_dig(bit [7:0] c); return c >= "0" && c <= "9"; endfunction
  function automatic bit is_alp(bit [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction
  function automatic bit is_sp(bit [7:0] c); return c == " " || (c >= 9 && c <= 13); endfunction
  function automatic bit is_bl(bit [7:0] c); return c == " " || c == 9; endfunction
  function automatic bit is_hex(bit [7:0] c);
    return is_dig(c) || ((c | 8'h20) >= "a" && (c | 8'h20) <= "f");
  endfunction
  function automatic bit [3:0] hexv(bit [7:0] c);
    return is_dig(c) ? 4'(c - "0") : 4'((c | 8'h20) - "a" + 10);
  endfunction
  function automatic bit [7:0] lowc(bit [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction
  function automatic bit is_bound(bit [7:0] c);
    return c inside {"(", ")", "{", "}", ",", ".", "<", "=", ">", "/", "+", "-", "*", "!"};
  endfunction

  function automatic void put_exp(bit [2:0] cls, bit [7:0] ch, bit has, bit last,
                                  bit [2:0] err);
    out_word_t w;
    w.token_class = cls;
    w.text_char   = ch;
    w.has_char    = has;
    w.token_last  = last;
    w.error_code  = err;
    token_q.push_back(w);
  endfunction

  function automatic void clear_tok();
    pend_v = 0; pend_ch = 0; tlen = 0; pfx = 0; held_n = 0; hex_hi = 0; nest = 0;
  endfunction

  function automatic void raise_err(bit [2:0] code);
    put_exp(CLS_NEWLINE, 8'd0, 1'b0, 1'b1, code);
    clear_tok();
    lmode = LX_START;
    halted = 1;
  endfunction

  function automatic bit take_char(bit [2:0] cls, bit [7:0] ch);
    if (halted) return 0;
    if (tlen >= TOKEN_MAX - 1) begin
      raise_err(ERR_OVERFLOW);
      return 0;
    end
    if (pend_v) put_exp(cls, pend_ch, 1'b1, 1'b0, ERR_NONE);
    pend_ch = ch;
    pend_v = 1;
    tlen++;
    return 1;
  endfunction

  function automatic void close_tok(bit [2:0] cls);
    if (pend_v) put_exp(cls, pend_ch, 1'b1, 1'b1, ERR_NONE);
    else put_exp(cls, 8'd0, 1'b0, 1'b1, ERR_NONE);
    clear_tok();
    lmode = LX_START;
  endfunction

  function automatic bit flush_held();
    for (int i = 0; i < held_n; i++)
      if (!take_char(CLS_STRING, held[i])) return 0;
    held_n = 0;
    return 1;
  endfunction

  function automatic void hold_byte(bit [7:0] c);
    if (held_n >= HOLD_MAX) raise_err(ERR_OVERFLOW);
    else begin
      held[held_n] = c;
      held_n++;
    end
  endfunction

  function automatic bit [2:0] ident_class();
    return (pfx[1:0] == 2'b11) ? CLS_GLOBAL : CLS_IDENT;
  endfunction

  function automatic void end_ident();
    if (tlen == 1 && pfx[0]) raise_err(ERR_INVALID);
    else if (pfx[2]) raise_err(ERR_INVALID);
    else close_tok(ident_class());
  endfunction

  function automatic void start_char(bit [7:0] c);
    clear_tok();
    if (c == 8'h0a) lmode = LX_NL;
    else if (is_bl(c)) begin
    end else if (c inside {"(", ")", "{", "}", ",", ".", "?", ":"})
      put_exp(CLS_SPECIAL, c, 1'b1, 1'b1, ERR_NONE);
    else if (c == "=") begin pend_ch = c; lmode = LX_EQ; end
    else if (c == "!") begin pend_ch = c; lmode = LX_NEQ; end
    else if (c == "<" || c == ">") begin pend_ch = c; lmode = LX_GL; end
    else if (c == "+" || c == "-" || c == "*") put_exp(CLS_ARITH, c, 1'b1, 1'b1, ERR_NONE);
    else if (c == "/") lmode = LX_SLASH;
    else if (c == "\"") lmode = LX_STR;
    else if (is_alp(c) || c == "_") begin
      pfx = (c == "_") ? 3'd1 : 3'd0;
      void'(take_char(CLS_IDENT, c));
      lmode = LX_IDENT;
    end else if (is_dig(c)) begin
      void'(take_char(CLS_NUMBER, c));
      lmode = (c == "0") ? LX_N_ZERO : LX_N_DEC;
    end else raise_err(ERR_UNSUPPORTED);
  endfunction

  function automatic void comment_step(bit [7:0] c, int base, int ret);
    int sub;
    sub = lmode - base;
    if (sub == 0) begin
      if (c == "*") lmode = base + 1;
      else if (c == "/") lmode = base + 2;
    end else if (sub == 1) begin
      if (c == "/") begin
        nest--;
        lmode = (nest == 0) ? ret : base;
      end else if (c != "*") lmode = base;
    end else begin
      if (c == "*") begin
        if (nest >= DEPTH_MAX) begin
          raise_err(ERR_OVERFLOW);
          return;
        end
        nest++;
      end
      lmode = base;
    end
  endfunction

  function automatic void num_take(bit [7:0] c, int nxt);
    if (take_char(CLS_NUMBER, c)) lmode = nxt;
  endfunction

  // returns 1 when the byte must be lexed again from the start state
  function automatic bit lex_char(bit [7:0] c);
    bit [7:0] lc;
    bit [7:0] v;
    lc = lowc(c);
    case (lmode)
      LX_START: begin start_char(c); return 0; end
      LX_NL: begin
        if (is_sp(c)) return 0;
        if (c == "/") begin lmode = LX_NL_SLASH; return 0; end
        put_exp(CLS_NEWLINE, 8'd0, 1'b0, 1'b1, ERR_NONE);
        lmode = LX_START;
        return 1;
      end
      LX_NL_SLASH: begin
        if (c == "*") begin nest = 1; lmode = LX_BCN_SEEK; return 0; end
        if (c == "/") begin lmode = LX_LINE; return 0; end
        put_exp(CLS_NEWLINE, 8'd0, 1'b0, 1'b1, ERR_NONE);
        put_exp(CLS_ARITH, "/", 1'b1, 1'b1, ERR_NONE);
        lmode = LX_START;
        return 1;
      end
      LX_SLASH: begin
        if (c == "*") begin nest = 1; lmode = LX_BC_SEEK; return 0; end
        if (c == "/") begin lmode = LX_LINE; return 0; end
        put_exp(CLS_ARITH, "/", 1'b1, 1'b1, ERR_NONE);
        lmode = LX_START;
        return 1;
      end
      LX_LINE: begin
        if (c == 8'h0a) lmode = LX_NL;
        return 0;
      end
      LX_BC_SEEK, LX_BC_STAR, LX_BC_SLASH: begin
        comment_step(c, LX_BC_SEEK, LX_START);
        return 0;
      end
      LX_BCN_SEEK, LX_BCN_STAR, LX_BCN_SLASH: begin
        comment_step(c, LX_BCN_SEEK, LX_NL);
        return 0;
      end
      LX_EQ: begin
        lmode = LX_START;
        if (c == "=") begin
          put_exp(CLS_COMPARE, "=", 1'b1, 1'b0, ERR_NONE);
          put_exp(CLS_COMPARE, "=", 1'b1, 1'b1, ERR_NONE);
          return 0;
        end
        put_exp(CLS_SPECIAL, "=", 1'b1, 1'b1, ERR_NONE);
        return 1;
      end
      LX_GL: begin
        lmode = LX_START;
        if (c == "=") begin
          put_exp(CLS_COMPARE, pend_ch, 1'b1, 1'b0, ERR_NONE);
          put_exp(CLS_COMPARE, "=", 1'b1, 1'b1, ERR_NONE);
          return 0;
        end
        put_exp(CLS_COMPARE, pend_ch, 1'b1, 1'b1, ERR_NONE);
        return 1;
      end
      LX_NEQ: begin
        if (c == "=") begin
          put_exp(CLS_COMPARE, "!", 1'b1, 1'b0, ERR_NONE);
          put_exp(CLS_COMPARE, "=", 1'b1, 1'b1, ERR_NONE);
          lmode = LX_START;
        end else raise_err(ERR_INVALID);
        return 0;
      end
      LX_STR: begin
        if (c == "\"") begin
          if (tlen == 0) lmode = LX_STR_EMPTY;
          else close_tok(CLS_STRING);
        end else if (c == "\\") lmode = LX_STR_ESC;
        else if (c < 32 || c == 127) raise_err(ERR_INVALID);
        else void'(take_char(CLS_STRING, c));
        return 0;
      end
      LX_STR_EMPTY: begin
        if (c == "\"") begin held_n = 0; lmode = LX_MULTI; return 0; end
        close_tok(CLS_STRING);
        return 1;
      end
      LX_STR_ESC: begin
        if (c == "x") begin lmode = LX_STR_HEX1; return 0; end
        case (c)
          "n": v = 8'd10;
          "t": v = 8'd9;
          "r": v = 8'd13;
          "\"": v = 8'd34;
          "\\": v = 8'd92;
          default: begin
            raise_err(ERR_INVALID);
            return 0;
          end
        endcase
        if (take_char(CLS_STRING, v)) lmode = LX_STR;
        return 0;
      end
      LX_STR_HEX1: begin
        if (!is_hex(c)) begin raise_err(ERR_INVALID); return 0; end
        hex_hi = hexv(c);
        lmode = LX_STR_HEX2;
        return 0;
      end
      LX_STR_HEX2: begin
        if (!is_hex(c)) begin raise_err(ERR_INVALID); return 0; end
        v = {hex_hi, hexv(c)};
        if (v > 8'h7f) begin raise_err(ERR_INVALID); return 0; end
        if (take_char(CLS_STRING, v)) lmode = LX_STR;
        return 0;
      end
      LX_MULTI: begin
        if (is_sp(c)) hold_byte(c);
        else if (c == "\"") begin
          hold_byte(c);
          if (!halted) lmode = LX_MULTI_Q;
        end else if (flush_held()) void'(take_char(CLS_STRING, c));
        return 0;
      end
      LX_MULTI_Q, LX_MULTI_END: begin
        if (c == "\"") begin
          if (lmode == LX_MULTI_END) begin
            held_n = 0;
            close_tok(CLS_STRING);
          end else begin
            hold_byte(c);
            if (!halted) lmode = LX_MULTI_END;
          end
        end else if (flush_held() && take_char(CLS_STRING, c)) lmode = LX_MULTI;
        return 0;
      end
      LX_IDENT: begin
        if (is_alp(c) || is_dig(c) || c == "_") begin
          if (tlen == 1 && c == "_" && pfx[0]) pfx[1] = 1;
          else if (tlen == 2 && pfx[1:0] == 2'b11 && !is_alp(c)) pfx[2] = 1;
          void'(take_char(ident_class(), c));
          return 0;
        end
        if (!is_sp(c) && !is_bound(c)) begin raise_err(ERR_INVALID); return 0; end
        end_ident();
        return !halted;
      end
      LX_N_ZERO: begin
        if (lc == "x") num_take("x", LX_N_HEX_START);
        else if (c == ".") num_take(c, LX_N_FRAC_START);
        else if (lc == "e") num_take("e", LX_N_EXP_SIGN);
        else if (c == "0") raise_err(ERR_INVALID);
        else begin close_tok(CLS_NUMBER); return 1; end
        return 0;
      end
      LX_N_DEC: begin
        if (is_dig(c)) num_take(c, LX_N_DEC);
        else if (c == ".") num_take(c, LX_N_FRAC_START);
        else if (lc == "e") num_take("e", LX_N_EXP_SIGN);
        else begin close_tok(CLS_NUMBER); return 1; end
        return 0;
      end
      LX_N_FRAC_START: begin
        if (is_dig(c)) num_take(c, LX_N_FRAC); else raise_err(ERR_INVALID);
        return 0;
      end
      LX_N_FRAC: begin
        if (is_dig(c)) num_take(c, LX_N_FRAC);
        else if (lc == "e") num_take("e", LX_N_EXP_SIGN);
        else begin close_tok(CLS_NUMBER); return 1; end
        return 0;
      end
      LX_N_EXP_SIGN: begin
        if (c == "+" || c == "-") num_take(c, LX_N_EXP_START);
        else if (is_dig(c)) num_take(c, LX_N_EXP);
        else raise_err(ERR_INVALID);
        return 0;
      end
      LX_N_EXP_START: begin
        if (is_dig(c)) num_take(c, LX_N_EXP); else raise_err(ERR_INVALID);
        return 0;
      end
      LX_N_EXP: begin
        if (is_dig(c)) begin num_take(c, LX_N_EXP); return 0; end
        close_tok(CLS_NUMBER);
        return 1;
      end
      LX_N_HEX_START: begin
        if (is_hex(c)) num_take(c, LX_N_HEX); else raise_err(ERR_INVALID);
        return 0;
      end
      LX_N_HEX: begin
        if (is_hex(c)) begin num_take(c, LX_N_HEX); return 0; end
        close_tok(CLS_NUMBER);
        return 1;
      end
      default: begin lmode = LX_START; return 1; end
    endcase
  endfunction

  function automatic void lex_end();
    case (lmode)
      LX_NL, LX_LINE: put_exp(CLS_NEWLINE, 8'd0, 1'b0, 1'b1, ERR_NONE);
      LX_NL_SLASH: begin
        put_exp(CLS_NEWLINE, 8'd0, 1'b0, 1'b1, ERR_NONE);
        put_exp(CLS_ARITH, "/", 1'b1, 1'b1, ERR_NONE);
      end
      LX_SLASH: put_exp(CLS_ARITH, "/", 1'b1, 1'b1, ERR_NONE);
      LX_BC_SEEK, LX_BC_STAR, LX_BC_SLASH, LX_BCN_SEEK, LX_BCN_STAR, LX_BCN_SLASH:
        raise_err(ERR_UNCLOSED);
      LX_EQ: put_exp(CLS_SPECIAL, "=", 1'b1, 1'b1, ERR_NONE);
      LX_GL: put_exp(CLS_COMPARE, pend_ch, 1'b1, 1'b1, ERR_NONE);
      LX_STR_EMPTY: close_tok(CLS_STRING);
      LX_IDENT: end_ident();
      LX_N_ZERO, LX_N_DEC, LX_N_FRAC, LX_N_EXP, LX_N_HEX: close_tok(CLS_NUMBER);
      LX_START: begin
      end
      default: raise_err(ERR_INVALID);
    endcase
    clear_tok();
    lmode = LX_START;
  endfunction

  function automatic void lex_word(in_word_t w);
    if (halted) return;
    if (w.end_of_input) begin
      lex_end();
      return;
    end
    for (int i = 0; i < 4; i++)
      if (!lex_char(w.source_char) || halted) break;
  endfunction

  // sender: leaves push high after acceptance; callers drop it with release_push
  task automatic send_word(bit [7:0] c, bit eoi);
    if (!calm && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    push <= 1'b1;
    din <= '{source_char: c, end_of_input: eoi};
    do @(posedge clk); while (full);
    lex_word('{source_char: c, end_of_input: eoi});
    words_sent++;
  endtask

  task automatic release_push();
    push <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
    release_push();
  endtask

  task automatic send_mark();
    send_word(8'($urandom_range(0, 255)), 1'b1);
    release_push();
  endtask

  task automatic send_raw(bit [7:0] c);
    send_word(c, 1'b0);
    release_push();
  endtask

  task automatic drain();
    while (token_q.size() != 0) @(posedge clk);
  endtask

  // result checker and pop driver
  initial begin
    int quiet;
    quiet = 0;
    pop = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        if (token_q.size() == 0) begin
          $error("unexpected word class=%0d char=%h", dout.token_class, dout.text_char);
          err_cnt++;
        end else begin
          out_word_t w;
          w = token_q.pop_front();
          if (dout.token_class !== w.token_class) begin
            $error("token_class exp %0d got %0d", w.token_class, dout.token_class);
            err_cnt++;
          end
          if (dout.text_char !== w.text_char) begin
            $error("text_char exp %h got %h", w.text_char, dout.text_char);
            err_cnt++;
          end
          if (dout.has_char !== w.has_char) begin
            $error("has_char exp %0d got %0d", w.has_char, dout.has_char);
            err_cnt++;
          end
          if (dout.token_last !== w.token_last) begin
            $error("token_last exp %0d got %0d", w.token_last, dout.token_last);
            err_cnt++;
          end
          if (dout.error_code !== w.error_code) begin
            $error("error_code exp %0d got %0d", w.error_code, dout.error_code);
            err_cnt++;
          end
        end
      end
      if (pop_hold > 0) begin
        pop_hold--;
        pop <= 1'b0;
      end else if (quiet > 0) begin
        quiet--;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        quiet = $urandom_range(0, 18);
        pop <= 1'b0;
      end else pop <= 1'b1;
    end
  end

  initial begin
    int cyc;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc >= CYCLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic test_operators();
    send_text("( ) { } , . ? : + - * / = == != < > <= >= <a>b=c\n");
  endtask

  task automatic test_names_numbers();
    send_text("_a __g1x abc_9 Z x(y) 0 09 0X1aF 3.25E+7 1e5 9.0e-1 0.5 7\n");
  endtask

  task automatic test_strings();
    send_text("\"hi\\n\\t\\r\\\"\\\\\\x7F\\x00\\x4a\" \"\" \"\"\"  a \" b\"\"c  \"\"\" ");
    send_text("\"");
    send_raw(8'hff);
    send_raw(8'h80);
    send_text("~\" ");
  endtask

  task automatic test_comments();
    send_text("a\n\n  // c\n/* x /* y */ z */ b\n/ c\n/* q */ d // e\n");
  endtask

  task automatic test_end_marks();
    send_text("k");   send_mark();
    send_text("12");  send_mark();
    send_text("/");   send_mark();
    send_text("=");   send_mark();
    send_text("<");   send_mark();
    send_text("\"\""); send_mark();
    send_text("// z"); send_mark();
    send_text("\n/"); send_mark();
    send_mark();
    send_word(8'hff, 1'b1);
    release_push();
  endtask

  function automatic bit [7:0] rand_letter();
    return $urandom_range(0, 1) ? 8'($urandom_range("a", "z")) : 8'($urandom_range("A", "Z"));
  endfunction

  function automatic bit [7:0] rand_alnum();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range("0", "9"));
      1: return "_";
      default: return rand_letter();
    endcase
  endfunction

  function automatic bit [7:0] rand_hexdig();
    string hs;
    hs = "0123456789abcdefABCDEF";
    return hs[$urandom_range(0, 21)];
  endfunction

  function automatic void add_str(ref bit [7:0] q[$], input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endfunction

  function automatic void add_digits(ref bit [7:0] q[$], input int n);
    for (int i = 0; i < n; i++) q.push_back(8'($urandom_range("0", "9")));
  endfunction

  function automatic void make_token(ref bit [7:0] q[$]);
    bit [7:0] c;
    string ops[20];
    ops = '{"(", ")", "{", "}", ",", ".", "?", ":", "+", "-", "*", "=", "==", "!=",
            "<", ">", "<=", ">=", "/", "/ "};
    case ($urandom_range(0, 9))
      0: begin
        q.push_back($urandom_range(0, 3) == 0 ? "_" : rand_letter());
        if (q[$] == "_") q.push_back(rand_letter());
        repeat ($urandom_range(0, 6)) q.push_back(rand_alnum());
      end
      1: begin
        add_str(q, "__");
        q.push_back(rand_letter());
        repeat ($urandom_range(0, 4)) q.push_back(rand_alnum());
      end
      2: begin
        q.push_back(8'($urandom_range("1", "9")));
        add_digits(q, $urandom_range(0, 4));
        if ($urandom_range(0, 1)) begin
          q.push_back(".");
          add_digits(q, $urandom_range(1, 3));
        end
        if ($urandom_range(0, 1)) begin
          q.push_back($urandom_range(0, 1) ? "e" : "E");
          case ($urandom_range(0, 2))
            0: q.push_back("+");
            1: q.push_back("-");
            default: begin
            end
          endcase
          add_digits(q, $urandom_range(1, 3));
        end
      end
      3: begin
        q.push_back("0");
        q.push_back($urandom_range(0, 1) ? "x" : "X");
        repeat ($urandom_range(1, 6)) q.push_back(rand_hexdig());
      end
      4: begin
        q.push_back("\"");
        repeat ($urandom_range(1, 8)) begin
          case ($urandom_range(0, 5))
            0: begin
              q.push_back("\\");
              case ($urandom_range(0, 4))
                0: q.push_back("n");
                1: q.push_back("t");
                2: q.push_back("r");
                3: q.push_back("\"");
                default: q.push_back("\\");
              endcase
            end
            1: begin
              add_str(q, "\\x");
              q.push_back(8'($urandom_range("0", "7")));
              q.push_back(rand_hexdig());
            end
            default: begin
              do c = 8'($urandom_range(32, 255)); while (c == 34 || c == 92 || c == 127);
              q.push_back(c);
            end
          endcase
        end
        q.push_back("\"");
      end
      5: add_str(q, "\"\"");
      6: begin
        add_str(q, "\"\"\"");
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(0, 4))
            0: repeat ($urandom_range(1, 4)) q.push_back(8'($urandom_range(9, 13)));
            1: begin q.push_back("\""); q.push_back(rand_letter()); end
            2: begin add_str(q, "\"\""); q.push_back(rand_letter()); end
            3: repeat ($urandom_range(1, 4)) q.push_back(" ");
            default: q.push_back(rand_alnum());
          endcase
        end
        repeat ($urandom_range(0, 6)) q.push_back($urandom_range(0, 1) ? " " : 8'h0a);
        add_str(q, "\"\"\"");
      end
      7: add_str(q, ops[$urandom_range(0, 19)]);
      8: begin
        case ($urandom_range(0, 4))
          0: add_str(q, "\n");
          1: add_str(q, "\n\n \t\n");
          2: begin
            add_str(q, "\n//");
            repeat ($urandom_range(0, 5)) begin
              do c = 8'($urandom_range(0, 255)); while (c == 8'h0a);
              q.push_back(c);
            end
            add_str(q, "\n");
          end
          3: add_str(q, "\n/* a /* b */ c */");
          default: add_str(q, "/* x * / */");
        endcase
      end
      default: q.push_back(8'h00);
    endcase
  endfunction

  task automatic test_random();
    bit [7:0] q[$];
    while (words_sent < RANDOM_ITEMS) begin
      q.delete();
      make_token(q);
      if (q.size() == 1 && q[0] == 8'h00) begin
        send_word(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        foreach (q[i]) send_word(q[i], 1'b0);
        send_word($urandom_range(0, 2) == 0 ? 8'h09 : " ", 1'b0);
      end
      if (words_sent > RANDOM_ITEMS * 3 / 4) calm = 1;
    end
    release_push();
  endtask

  task automatic test_backpressure();
    pop_hold = 200;
    calm = 1;
    send_text("alpha = beta + 42 / __d\n");
    calm = 0;
  endtask

  task automatic test_halt();
    send_text(" 5 ");
    send_raw("$");
    send_text("ab cd 12 ");
  endtask

  initial begin
    rst = 1'b1;
    push = 1'b0;
    din = '0;
    err_cnt = 0;
    words_sent = 0;
    calm = 0;
    pop_hold = 0;
    lmode = LX_START;
    clear_tok();
    halted = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_operators();
    test_names_numbers();
    test_strings();
    test_comments();
    test_end_marks();
    test_backpressure();
    words_sent = 0;
    test_random();
    test_halt();
    drain();
    repeat (20) @(posedge clk);
    if (err_cnt == 0 && token_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
